// ===== rtl/bsrb_pkg.sv =====
// bsrb_pkg: shared constants, types and helpers of the beam slot ring buffer
`timescale 1ns / 1ps

package bsrb_pkg;

    // ring geometry
    localparam int MAX_SLOTS = 256;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SC_W      = 9;
    localparam int EFF_W     = (SC_W > CNT_W) ? SC_W : CNT_W;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int LEN_W     = 16;
    localparam int BYTES_W   = 16;
    localparam int OFF_W     = 24;
    localparam int STAT_W    = 2;
    localparam int DROP_W    = 32;
    localparam int PROD_W    = IDX_W + BYTES_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // reset values of the configuration registers
    localparam logic [SC_W-1:0]    SLOT_COUNT_RST = SC_W'(256);
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = BYTES_W'(2048);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = CFG_IDX_W'(1);

    // function codes
    localparam logic [FUNC_W-1:0] FN_WRITE_DONE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_GET_BEAM   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RESYNC     = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROP  = 2'd2;

    // contents of the middle pipeline stage
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              rd_ok;
        logic [IDX_W-1:0]  ridx;
        logic [IDX_W-1:0]  widx;
        logic [DROP_W-1:0] drops;
    } t_s1;

    // effective slot count, clamped into 2..MAX_SLOTS
    function automatic logic [EFF_W-1:0] eff_count(input logic [SC_W-1:0] sc);
        logic [EFF_W-1:0] v;
        v = EFF_W'(sc);
        if (v < EFF_W'(2)) begin
            v = EFF_W'(2);
        end else if (v > EFF_W'(MAX_SLOTS)) begin
            v = EFF_W'(MAX_SLOTS);
        end
        return v;
    endfunction

    // next index around the ring
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                   input logic [EFF_W-1:0] eff);
        logic [EFF_W-1:0] v;
        v = EFF_W'(idx) + EFF_W'(1);
        return (v >= eff) ? '0 : v[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/bsrb_ram.sv =====
// bsrb_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module bsrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/beam_slot_ring_buffer_top.sv =====
// beam_slot_ring_buffer_top: ring of beam slots with stored lengths and a drop counter
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_ready) carries one command per transfer:
//   write_done with a beam length, get_beam, or resync. Every command gives
//   exactly one result on the output channel (o_out_valid / i_out_ready):
//   status, read offset and length, next write offset and the drop count.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   slot_count (index 0) and slot_bytes (index 1); write only while idle.
//   The result passes the middle stage, which waits for the registered read
//   of the slot length ram, and then the output register.
//   Throughput: one command per cycle while the receiver keeps up.
//   Reset: read and write index and drop count clear, slot_count becomes
//   256 and slot_bytes 2048. The length ram is not cleared; a slot is only
//   read after it has been written.
//   Stall: the middle stage and output register hold their items; o_in_ready
//   drops while both are full and i_out_ready is low, rises as the output is taken.
module beam_slot_ring_buffer_top
    import bsrb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [LEN_W-1:0]      i_beam_length,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STAT_W-1:0]     o_status,
    output logic [OFF_W-1:0]      o_read_offset,
    output logic [LEN_W-1:0]      o_read_length,
    output logic [OFF_W-1:0]      o_write_offset,
    output logic [DROP_W-1:0]     o_drops,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    logic [SC_W-1:0]    r_slot_count;
    logic [BYTES_W-1:0] r_slot_bytes;
    logic [IDX_W-1:0]   r_read_idx, n_read_idx;
    logic [IDX_W-1:0]   r_write_idx, n_write_idx;
    logic [DROP_W-1:0]  r_drops, n_drops;

    logic               r_s1_valid;
    t_s1                r_s1, n_s1;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [OFF_W-1:0]   r_out_roff;
    logic [LEN_W-1:0]   r_out_rlen;
    logic [OFF_W-1:0]   r_out_woff;
    logic [DROP_W-1:0]  r_out_drops;

    logic [EFF_W-1:0]   w_eff;
    logic [IDX_W-1:0]   w_wnext;
    logic [IDX_W-1:0]   w_rnext;
    logic               w_full;
    logic               w_empty;
    logic               w_adv_out;
    logic               w_s1_ready;
    logic               w_accept;
    logic               w_ram_we;
    logic               w_ram_re;
    logic [LEN_W-1:0]   w_ram_rdata;
    logic [PROD_W-1:0]  w_rprod;
    logic [PROD_W-1:0]  w_wprod;

    // pipeline flow control
    assign w_adv_out  = !r_out_valid || i_out_ready;
    assign w_s1_ready = !r_s1_valid || w_adv_out;
    assign w_accept   = i_in_valid && w_s1_ready;

    assign o_in_ready  = w_s1_ready;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SLOT_COUNT_RST;
            r_slot_bytes <= SLOT_BYTES_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_SLOT_COUNT) begin
                r_slot_count <= i_cfg_data[SC_W-1:0];
            end else if (i_cfg_index == REG_SLOT_BYTES) begin
                r_slot_bytes <= i_cfg_data[BYTES_W-1:0];
            end
        end
    end

    // ring pointer arithmetic
    assign w_eff   = eff_count(r_slot_count);
    assign w_wnext = ring_next(r_write_idx, w_eff);
    assign w_rnext = ring_next(r_read_idx, w_eff);
    assign w_full  = (w_wnext == r_read_idx);
    assign w_empty = (r_read_idx == r_write_idx);

    // command decode and next state
    always_comb begin
        n_read_idx  = r_read_idx;
        n_write_idx = r_write_idx;
        n_drops     = r_drops;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        n_s1.status = ST_OK;
        n_s1.rd_ok  = 1'b0;
        case (i_func)
            FN_WRITE_DONE: begin
                w_ram_we = 1'b1;
                if (w_full) begin
                    if (r_drops != '1) begin
                        n_drops = r_drops + DROP_W'(1);
                    end
                    n_s1.status = ST_DROP;
                end else begin
                    n_write_idx = w_wnext;
                end
            end
            FN_GET_BEAM: begin
                if (w_empty) begin
                    n_s1.status = ST_EMPTY;
                end else begin
                    w_ram_re    = 1'b1;
                    n_s1.rd_ok  = 1'b1;
                    n_read_idx  = w_rnext;
                end
            end
            FN_RESYNC: begin
                n_read_idx = r_write_idx;
            end
            default: begin
            end
        endcase
        n_s1.ridx  = r_read_idx;
        n_s1.widx  = n_write_idx;
        n_s1.drops = n_drops;
    end

    // ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_idx  <= '0;
            r_write_idx <= '0;
            r_drops     <= '0;
        end else if (w_accept) begin
            r_read_idx  <= n_read_idx;
            r_write_idx <= n_write_idx;
            r_drops     <= n_drops;
        end
    end

    // slot length memory
    bsrb_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_ram_we),
        .i_waddr (r_write_idx),
        .i_wdata (i_beam_length),
        .i_re    (w_accept && w_ram_re),
        .i_raddr (r_read_idx),
        .o_rdata (w_ram_rdata)
    );

    // middle stage, waits for the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    // offset scaling
    assign w_rprod = PROD_W'(r_s1.ridx) * PROD_W'(r_slot_bytes);
    assign w_wprod = PROD_W'(r_s1.widx) * PROD_W'(r_slot_bytes);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out && r_s1_valid) begin
            r_out_status <= r_s1.status;
            r_out_roff   <= w_rprod[OFF_W-1:0];
            r_out_rlen   <= r_s1.rd_ok ? w_ram_rdata : '0;
            r_out_woff   <= w_wprod[OFF_W-1:0];
            r_out_drops  <= r_s1.drops;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_read_offset  = r_out_roff;
    assign o_read_length  = r_out_rlen;
    assign o_write_offset = r_out_woff;
    assign o_drops        = r_out_drops;

    // checks

    // a dropped beam is always counted
    a_drop_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_DROP) |-> (o_drops != '0))
        else $error("drop reported with zero drop count");

    // only a successful get hands out a length
    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_read_length == '0))
        else $error("nonzero length on a failed command");

    // a write_done into a ring with room moves the write index
    a_write_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_func == FN_WRITE_DONE) && !w_full
        |=> (r_write_idx != $past(r_write_idx)))
        else $error("write index did not advance");

    // a stalled middle stage keeps its item
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv_out |=> r_s1_valid && $stable(r_s1))
        else $error("middle stage lost an item under stall");

endmodule
